// ===== rtl/core/mtf_pkg.sv =====
// mtf_pkg: shared types and codes for the max-tracking queue.
// No dependencies; used by mtf_cell and max_tracking_fifo.
package mtf_pkg;

  localparam int DATA_W  = 16;
  localparam int DEPTH   = 16;
  // Live count must hold DEPTH itself.
  localparam int COUNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [DATA_W-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  front_value;
    logic [DATA_W-1:0]  back_value;
    logic [DATA_W-1:0]  max_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic [1:0]         status;
  } rsp_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETTLE,
    S_DRAIN
  } state_t;

endpackage

// ===== rtl/core/max_tracking_fifo.sv =====
// max_tracking_fifo: queue with running maximum, built as a row of mtf_cell.
// Depends on mtf_pkg and mtf_cell.
//
//   channel | direction | payload           | handshake
//   --------+-----------+-------------------+-----------------------
//   req     | in        | mtf_pkg::req_t    | req_valid / req_ready
//   rsp     | out       | mtf_pkg::rsp_t    | rsp_valid / rsp_ready
//
// No new item is taken until the last result is loaded. The slots update at
// the accept edge; the max and back values then ripple down the cell row one
// cell per cycle, and the result register loads from the drain state.
// Reset (rst, synchronous): queue empty, no result pending, ready to accept.
// Stalls: a held result does not block the next accept; the new result waits
// in the drain state until the output register frees.
module max_tracking_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  mtf_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mtf_pkg::rsp_t  rsp
);

  localparam int DEPTH = mtf_pkg::DEPTH;
  localparam int CW = $clog2(DEPTH + 1);  // live count, holds DEPTH
  localparam int SW = $clog2(DEPTH);      // settle counter, 0..DEPTH-1

  mtf_pkg::state_t     state, state_next;
  logic [SW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       count;
  logic [1:0]          status;
  mtf_pkg::cell_ctrl_t ctrl;
  logic                accept, full, empty, load_rsp;
  logic [1:0]          status_next;

  logic [DEPTH-1:0]             cell_valid;
  logic [mtf_pkg::DATA_W-1:0]   cell_value [DEPTH];
  logic [mtf_pkg::DATA_W-1:0]   cell_max   [DEPTH];
  logic [mtf_pkg::DATA_W-1:0]   cell_back  [DEPTH];

  assign accept = req_valid && req_ready;
  assign full   = cell_valid[DEPTH-1];
  assign empty  = !cell_valid[0];

  // Command decode; code 3 behaves like a query.
  always_comb begin
    ctrl        = '0;
    status_next = mtf_pkg::ST_OK;
    unique case (req.command)
      mtf_pkg::CMD_PUSH: begin
        if (full) begin
          status_next = mtf_pkg::ST_OVERFLOW;
        end else begin
          ctrl.push = accept;
        end
      end
      mtf_pkg::CMD_POP: begin
        if (empty) begin
          status_next = mtf_pkg::ST_UNDERFLOW;
        end else begin
          ctrl.pop = accept;
        end
      end
      default: begin
        if (empty) begin
          status_next = mtf_pkg::ST_UNDERFLOW;
        end
      end
    endcase
  end

  // Cell row: head at index 0, pops shift toward it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                       pv;
    logic [mtf_pkg::DATA_W-1:0] pm, pb, sv;
    logic                       svalid;

    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pm = '0;
      assign pb = '0;
    end else begin : g_body
      assign pv = cell_valid[i-1];
      assign pm = cell_max[i-1];
      assign pb = cell_back[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign svalid = 1'b0;
      assign sv     = '0;
    end else begin : g_mid
      assign svalid = cell_valid[i+1];
      assign sv     = cell_value[i+1];
    end

    mtf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .push_value (req.data_value),
      .prev_valid (pv),
      .prev_max   (pm),
      .prev_back  (pb),
      .succ_valid (svalid),
      .succ_value (sv),
      .valid      (cell_valid[i]),
      .value      (cell_value[i]),
      .run_max    (cell_max[i]),
      .run_back   (cell_back[i])
    );
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtf_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    load_rsp   = 1'b0;
    req_ready  = 1'b0;
    unique case (state)
      mtf_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = mtf_pkg::S_SETTLE;
          cnt_next   = '0;
        end
      end
      mtf_pkg::S_SETTLE: begin
        cnt_next = cnt + 1'b1;
        if (cnt == SW'(DEPTH - 1)) begin
          state_next = mtf_pkg::S_DRAIN;
        end
      end
      mtf_pkg::S_DRAIN: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = mtf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mtf_pkg::S_IDLE;
      end
    endcase
  end

  // Live count and status of the item in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + 1'b1;
    end else if (ctrl.pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  // Output register; empty queue gives zeros from the chain ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.front_value <= cell_valid[0] ? cell_value[0] : '0;
      rsp.back_value  <= cell_back[DEPTH-1];
      rsp.max_value   <= cell_max[DEPTH-1];
      rsp.entry_count <= mtf_pkg::COUNT_W'(count);
      rsp.is_empty    <= empty;
      rsp.status      <= status;
    end
  end

  // Occupied cells form a contiguous run from the head.
  a_contig: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("cell valid bits not contiguous");

  a_count_head: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] == (count != '0))
    else $error("live count disagrees with head cell");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> count == CW'($past(count) + 1'b1))
    else $error("push did not grow the count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_empty) |->
      (rsp.max_value == '0 && rsp.front_value == '0 && rsp.back_value == '0))
    else $error("empty result carries data");

endmodule

// ===== rtl/core/mtf_cell.sv =====
// mtf_cell: one queue slot plus its stage of the running max / back chain.
// Depends on mtf_pkg.
module mtf_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  mtf_pkg::cell_ctrl_t       ctrl,
  input  logic [mtf_pkg::DATA_W-1:0] push_value,
  input  logic                      prev_valid,
  input  logic [mtf_pkg::DATA_W-1:0] prev_max,
  input  logic [mtf_pkg::DATA_W-1:0] prev_back,
  input  logic                      succ_valid,
  input  logic [mtf_pkg::DATA_W-1:0] succ_value,
  output logic                      valid,
  output logic [mtf_pkg::DATA_W-1:0] value,
  output logic [mtf_pkg::DATA_W-1:0] run_max,
  output logic [mtf_pkg::DATA_W-1:0] run_back
);

  logic take_push;

  // Push lands in the first empty slot.
  assign take_push = ctrl.push && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= succ_valid;
    end else if (take_push) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      value <= succ_value;
    end else if (take_push) begin
      value <= push_value;
    end
  end

  // Chain stages: one cell per cycle toward the tail.
  always_ff @(posedge clk) begin
    run_max  <= (valid && (value > prev_max)) ? value : prev_max;
    run_back <= valid ? value : prev_back;
  end

endmodule

// ===== tb/sv/tb_max_tracking_fifo.sv =====
`timescale 1ns / 100ps
// tb_max_tracking_fifo: self-checking bench for the max-tracking queue.
// Depends on mtf_pkg (beat types, command and status codes) and max_tracking_fifo.
module tb_max_tracking_fifo;
  import mtf_pkg::*;

  // Unused command code; the block must treat it as a query.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // Long receiver hold-off, well past the time the block needs to back up.
  localparam int HOLD_CYCLES = 400;
  // Settle time after the last result, beyond a pass through the cell row.
  localparam int DRAIN_CYCLES = DEPTH + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  req_t              pending_ops[$];   // beats waiting to be offered
  rsp_t              expected_rsp[$];  // predicted results, oldest first
  logic [DATA_W-1:0] shadow_q[$];      // our copy of the queue contents

  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;
  logic hold_pulse = 1'b0;
  int   hold_left = 0;
  int   error_count = 0;

  max_tracking_fifo DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one operation to the shadow queue and return the result the block
  // should give: every field reflects the queue after the operation.
  function automatic rsp_t apply_queue_op(req_t op);
    rsp_t              res;
    logic [DATA_W-1:0] top;
    res = '0;
    res.status = ST_OK;
    case (op.command)
      CMD_PUSH: begin
        // full queue: value dropped, contents untouched
        if (shadow_q.size() >= DEPTH) res.status = ST_OVERFLOW;
        else shadow_q.push_back(op.data_value);
      end
      CMD_POP: begin
        if (shadow_q.size() == 0) res.status = ST_UNDERFLOW;
        else void'(shadow_q.pop_front());
      end
      default: begin
        // query, and the spare code behaves the same
        if (shadow_q.size() == 0) res.status = ST_UNDERFLOW;
      end
    endcase
    if (shadow_q.size() != 0) begin
      top = '0;
      foreach (shadow_q[k]) if (shadow_q[k] > top) top = shadow_q[k];
      res.front_value = shadow_q[0];
      res.back_value  = shadow_q[$];
      res.max_value   = top;
    end
    res.entry_count = COUNT_W'(shadow_q.size());
    res.is_empty    = (shadow_q.size() == 0);
    return res;
  endfunction

  task automatic report_error(string what, int unsigned got, int unsigned want);
    error_count++;
    $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic queue_op(logic [1:0] cmd, logic [DATA_W-1:0] val);
    req_t op;
    op.command    = cmd;
    op.data_value = val;
    pending_ops.push_back(op);
  endtask

  // Random beats in runs that lean toward pushing or popping, so the
  // queue swings between empty and full and the max keeps moving.
  task automatic queue_random(int n);
    int                run_left;
    int                push_pct;
    int                pick;
    logic [1:0]        cmd;
    logic [DATA_W-1:0] val;
    run_left = 0;
    push_pct = 50;
    repeat (n) begin
      if (run_left == 0) begin
        run_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 55;
          default: push_pct = 85;
        endcase
      end
      run_left--;
      pick = $urandom_range(99);
      if (pick < push_pct) cmd = CMD_PUSH;
      else if (pick < 90) cmd = CMD_POP;
      else if (pick < 97) cmd = CMD_QUERY;
      else cmd = CMD_SPARE;
      // small values give ties and frequent max changes; extremes hit edges
      case ($urandom_range(9))
        0:       val = '0;
        1:       val = '1;
        2, 3:    val = DATA_W'($urandom_range(15));
        default: val = DATA_W'($urandom);
      endcase
      queue_op(cmd, val);
    end
  endtask

  // One stretch of traffic under a given idling mix. With squeeze set the
  // receiver is held off for a long run while the sender keeps offering.
  task automatic run_phase(int send_pct, int stall_pct, int n, bit squeeze);
    @(posedge clk);
    send_idle_pct <= send_pct;
    rsp_stall_pct <= stall_pct;
    queue_random(n);
    if (squeeze) begin
      hold_pulse <= 1'b1;
      @(posedge clk);
      hold_pulse <= 1'b0;
    end
    while (pending_ops.size() != 0) @(posedge clk);
  endtask

  // Request driver: a beat stays up, unchanged, until taken; idle gaps are
  // only rolled when nothing is on the bus.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (pending_ops.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
        req       <= pending_ops.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Hold-off counter for the backpressure stretch.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_pulse) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side: random stalls, plus the long hold-off when armed.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !hold_pulse && hold_left == 0
                   && int'($urandom_range(99)) >= rsp_stall_pct;
    end
  end

  // Monitor: predict on every accepted request beat, check every accepted
  // result beat against the oldest prediction.
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_rsp.push_back(apply_queue_op(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report_error("result beat with nothing pending", 32'(rsp.front_value), 32'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.front_value != want.front_value)
            report_error("front_value", 32'(rsp.front_value), 32'(want.front_value));
          if (rsp.back_value != want.back_value)
            report_error("back_value", 32'(rsp.back_value), 32'(want.back_value));
          if (rsp.max_value != want.max_value)
            report_error("max_value", 32'(rsp.max_value), 32'(want.max_value));
          if (rsp.entry_count != want.entry_count)
            report_error("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
          if (rsp.is_empty != want.is_empty)
            report_error("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
          if (rsp.status != want.status)
            report_error("status", 32'(rsp.status), 32'(want.status));
        end
      end
    end
  end

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: underflow on an empty queue for each non-push code, extreme
    // values, drain back to empty, fill to the brim, then one push too many.
    queue_op(CMD_QUERY, 16'h1234);
    queue_op(CMD_POP,   16'hFFFF);
    queue_op(CMD_SPARE, 16'h5A5A);
    queue_op(CMD_PUSH,  16'h0000);
    queue_op(CMD_PUSH,  16'hFFFF);
    queue_op(CMD_SPARE, 16'hA5A5);
    queue_op(CMD_POP,   16'h0000);
    queue_op(CMD_POP,   16'h0000);
    for (i = 0; i < DEPTH; i++)
      queue_op(CMD_PUSH, (i == 7) ? 16'hFFFF : DATA_W'(16'h0101 * (DEPTH - i)));
    queue_op(CMD_PUSH, 16'hABCD);

    // Random traffic under each idling mix; the last one is the squeeze.
    run_phase(0,  0,  255, 1'b0);
    run_phase(65, 0,  255, 1'b0);
    run_phase(0,  65, 255, 1'b0);
    run_phase(18, 18, 255, 1'b0);
    run_phase(0,  0,  255, 1'b1);

    while (pending_ops.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** max_tracking_fifo: PASSED **");
    end else begin
      $display("** max_tracking_fifo: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("** max_tracking_fifo: FAILED **");
    $finish;
  end

endmodule
